FILE: rtl/smtp_eod_pkg.sv
package smtp_eod_pkg;

    // Characters of the terminator sequence.
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_DOT = 8'h2E;

    // Widest partial match that can be held back (CR LF . CR).
    localparam int unsigned MAX_HELD = 4;
    localparam int unsigned HELD_W   = $clog2(MAX_HELD + 1);

    // What follows the released held bytes in one job.
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_BYTE,
        TAIL_DONE
    } tail_t;

    // One job handed from the classifier to the output sequencer.
    typedef struct packed {
        logic [HELD_W-1:0] held_cnt;
        tail_t             tail;
        logic [7:0]        data;
    } job_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Byte at position idx of the held-back partial terminator.
    function automatic logic [7:0] held_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = CH_CR;
            2'd1:    b = CH_LF;
            2'd2:    b = CH_DOT;
            default: b = CH_CR;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/smtp_eod_front.sv
module smtp_eod_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                operation,
    input  logic [7:0]          in_byte,
    output logic                push,
    output smtp_eod_pkg::job_t  job
);

    typedef enum logic [2:0] {
        ST_BODY      = 3'd0,
        ST_CR        = 3'd1,
        ST_CRLF      = 3'd2,
        ST_CRLFDOT   = 3'd3,
        ST_CRLFDOTCR = 3'd4,
        ST_DONE      = 3'd5
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   mismatch;
    logic   has_result;

    always_comb
    begin
        state_next   = state_reg;
        mismatch     = 1'b0;
        has_result   = 1'b0;
        job.held_cnt = '0;
        job.tail     = smtp_eod_pkg::TAIL_NONE;
        job.data     = in_byte;
        if (operation)
        begin
            state_next = ST_BODY;
        end
        else
        begin
            unique case (state_reg)
                ST_BODY:
                begin
                    if (in_byte == smtp_eod_pkg::CH_CR) state_next = ST_CR;
                    else                                mismatch   = 1'b1;
                end
                ST_CR:
                begin
                    if (in_byte == smtp_eod_pkg::CH_LF) state_next = ST_CRLF;
                    else                                mismatch   = 1'b1;
                end
                ST_CRLF:
                begin
                    if (in_byte == smtp_eod_pkg::CH_DOT) state_next = ST_CRLFDOT;
                    else                                 mismatch   = 1'b1;
                end
                ST_CRLFDOT:
                begin
                    if (in_byte == smtp_eod_pkg::CH_CR) state_next = ST_CRLFDOTCR;
                    else                                mismatch   = 1'b1;
                end
                ST_CRLFDOTCR:
                begin
                    if (in_byte == smtp_eod_pkg::CH_LF)
                    begin
                        state_next = ST_DONE;
                        job.tail   = smtp_eod_pkg::TAIL_DONE;
                        job.data   = '0;
                        has_result = 1'b1;
                    end
                    else
                    begin
                        mismatch = 1'b1;
                    end
                end
                ST_DONE:
                begin
                    state_next = ST_DONE;
                end
                default:
                begin
                    state_next = ST_DONE;
                end
            endcase

            // On a failed match the held bytes go out; a CR is kept back as a
            // fresh partial match rather than released.
            if (mismatch)
            begin
                job.held_cnt = smtp_eod_pkg::HELD_W'(state_reg);
                if (in_byte == smtp_eod_pkg::CH_CR)
                begin
                    job.tail   = smtp_eod_pkg::TAIL_NONE;
                    state_next = ST_CR;
                    has_result = (state_reg != ST_BODY);
                end
                else
                begin
                    job.tail   = smtp_eod_pkg::TAIL_BYTE;
                    state_next = ST_BODY;
                    has_result = 1'b1;
                end
            end
        end
    end

    assign push = accept && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BODY;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (job.held_cnt != '0 || job.tail != smtp_eod_pkg::TAIL_NONE))
        else $error("empty job pushed");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !operation) |-> !push)
        else $error("result after end of message");

    a_restart_body: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation) |=> (state_reg == ST_BODY))
        else $error("restart did not return to body");

endmodule

FILE: rtl/smtp_eod_fifo.sv
module smtp_eod_fifo
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  smtp_eod_pkg::job_t       push_job,
    input  logic                     pop,
    output smtp_eod_pkg::job_t       head_job,
    output smtp_eod_pkg::fifo_stat_t stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    smtp_eod_pkg::job_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)      count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push) count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("pop from empty queue");

endmodule

FILE: rtl/smtp_eod_back.sv
module smtp_eod_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  smtp_eod_pkg::job_t       head_job,
    input  smtp_eod_pkg::fifo_stat_t stat,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               out_byte,
    output logic                     byte_valid,
    output logic                     end_of_message,
    output logic                     last
);

    localparam int unsigned HW = smtp_eod_pkg::HELD_W;

    logic [HW-1:0] idx_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          byte_valid_reg;
    logic          eom_reg;
    logic          last_reg;

    logic          load;
    logic          adv;
    logic [HW-1:0] total;
    logic [7:0]    res_byte;
    logic          res_valid;
    logic          res_eom;
    logic          res_last;

    assign load  = !out_valid_reg || !out_stall;
    assign adv   = load && !stat.empty;
    assign total = head_job.held_cnt
                 + HW'(head_job.tail != smtp_eod_pkg::TAIL_NONE);

    always_comb
    begin
        res_last = (idx_reg + HW'(1) == total);
        if (idx_reg < head_job.held_cnt)
        begin
            res_byte  = smtp_eod_pkg::held_byte(idx_reg[1:0]);
            res_valid = 1'b1;
            res_eom   = 1'b0;
        end
        else if (head_job.tail == smtp_eod_pkg::TAIL_DONE)
        begin
            res_byte  = '0;
            res_valid = 1'b0;
            res_eom   = 1'b1;
        end
        else
        begin
            res_byte  = head_job.data;
            res_valid = 1'b1;
            res_eom   = 1'b0;
        end
    end

    assign pop = adv && res_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load) out_valid_reg <= !stat.empty;
            if (adv)  idx_reg       <= res_last ? '0 : idx_reg + HW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg   <= res_byte;
            byte_valid_reg <= res_valid;
            eom_reg        <= res_eom;
            last_reg       <= res_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign byte_valid     = byte_valid_reg;
    assign end_of_message = eom_reg;
    assign last           = last_reg;

    a_eom_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eom_reg) |-> (!byte_valid_reg && last_reg))
        else $error("done marker malformed");

    a_status_is_eom: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !byte_valid_reg) |-> eom_reg)
        else $error("status result without end of message");

endmodule

FILE: rtl/smtp_end_of_data_detector.sv
// End-of-data detector for an SMTP message body. Each input item either feeds
// one body byte (operation 0) or restarts the parser for a new message
// (operation 1). A front classifier runs the CR LF . CR LF matcher and accepts
// one item every clock cycle while its job queue has room; bytes that might
// belong to the terminator are held back, and when a partial match fails it
// queues a job that releases the held bytes followed by the current byte, so
// one item can give up to five result items. A CR that breaks a match is kept
// back as the start of a new match. Terminator bytes are never released; the
// final LF gives one status-only item with end_of_message set, after which
// bytes give nothing until a restart. No dot-unstuffing is done. The back part
// pops jobs from a FIFO_DEPTH-entry queue and sends one result item per cycle
// through a registered output while out_stall is low, and the queue absorbs
// bursts; since the average is at most one result per item, a steady stream
// runs at one item per cycle while the output is not stalled. When the queue
// and the output register are idle, the first result of an item is written
// into the queue and then loaded into the output register. The flag last marks
// the final result of each item that gives any results.
module smtp_end_of_data_detector
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       end_of_message,
    output logic       last
);

    smtp_eod_pkg::job_t       push_job;
    smtp_eod_pkg::job_t       head_job;
    smtp_eod_pkg::fifo_stat_t stat;
    logic                     accept;
    logic                     push;
    logic                     pop;

    // The front stalls only when the queue is full; it never waits on the
    // output side directly.
    assign in_stall = stat.full;
    assign accept   = in_valid && !in_stall;

    smtp_eod_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .in_byte   (in_byte),
        .push      (push),
        .job       (push_job)
    );

    smtp_eod_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (stat)
    );

    smtp_eod_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .stat           (stat),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .last           (last)
    );

endmodule

FILE: verif/tb_smtp_end_of_data_detector.sv
module tb_smtp_end_of_data_detector;

    // Operation codes of an input item.
    localparam logic OP_FEED    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam int RAND_ITEMS = 330;
    localparam int QUIET_MAX  = 2000;
    localparam int HOLD_LEN   = 80;
    localparam int TAIL_WAIT  = 12;
    localparam int DIR_N      = 25;

    // Matcher state: until M_DONE, the code equals the number of terminator bytes held back.
    typedef enum logic [2:0] {
        M_BODY,
        M_CR,
        M_CRLF,
        M_CRLFDOT,
        M_CRLFDOTCR,
        M_DONE
    } match_t;

    // Stimulus phases, each with its own idling pattern.
    typedef enum int {
        PH_FREE,
        PH_PRESSURE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } phase_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0] data;
        logic       vld;
        logic       eom;
        logic       lst;
    } eod_res_t;

    // One row of the directed table. Where typed is set, the row carries its own
    // expectation (n_res results, at most one) instead of the predictor's.
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       typed;
        logic       n_res;
        eod_res_t   res;
    } dir_row_t;

    localparam eod_res_t NO_RES = '0;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       operation = OP_FEED;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic       last;

    // The directed items: extremes of the byte, a failed partial match at every
    // depth, a CR that breaks a match and starts a new one, a restart that drops
    // held bytes, the full terminator, a byte after it, and a restart.
    dir_row_t dir_tab [DIR_N] = '{
        '{OP_FEED,    8'h00,                1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
        '{OP_FEED,    8'hFF,                1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b1}},
        '{OP_FEED,    smtp_eod_pkg::CH_CR,  1'b1, 1'b0, NO_RES},
        '{OP_FEED,    8'h41,                1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_CR,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_LF,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    8'h80,                1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_CR,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_LF,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_DOT, 1'b0, 1'b0, NO_RES},
        '{OP_FEED,    8'h55,                1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_CR,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_LF,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_DOT, 1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_CR,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_CR,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_LF,  1'b0, 1'b0, NO_RES},
        '{OP_RESTART, 8'hFF,                1'b1, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_CR,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_LF,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_DOT, 1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_CR,  1'b0, 1'b0, NO_RES},
        '{OP_FEED,    smtp_eod_pkg::CH_LF,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{OP_FEED,    8'h7A,                1'b1, 1'b0, NO_RES},
        '{OP_RESTART, 8'h0D,                1'b1, 1'b0, NO_RES}
    };

    // The terminator, and the bytes held back at each depth of a partial match.
    logic [7:0] term_seq [5] = '{smtp_eod_pkg::CH_CR, smtp_eod_pkg::CH_LF,
                                 smtp_eod_pkg::CH_DOT, smtp_eod_pkg::CH_CR,
                                 smtp_eod_pkg::CH_LF};

    match_t   match_st = M_BODY;
    eod_res_t released [$];
    eod_res_t pending_results [$];
    int       n_accepted = 0;
    int       n_items = 0;
    int       n_fail = 0;
    int       quiet = 0;
    phase_t   phase = PH_FREE;
    int       send_idle_pct = 0;
    int       stall_pct = 0;

    smtp_end_of_data_detector u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Predictor: advances the matcher by one item and leaves the result items
    // that it releases in 'released', the final one marked as last.
    task automatic terminator_step(input logic op, input logic [7:0] b);
        eod_res_t r;
        int       k;
        released.delete();
        if (op == OP_RESTART)
        begin
            // Held bytes are simply dropped.
            match_st = M_BODY;
        end
        else if (match_st >= M_DONE)
        begin
            // After the terminator every byte is ignored until a restart.
            match_st = M_DONE;
        end
        else if ((match_st == M_BODY    && b == smtp_eod_pkg::CH_CR)  ||
                 (match_st == M_CR      && b == smtp_eod_pkg::CH_LF)  ||
                 (match_st == M_CRLF    && b == smtp_eod_pkg::CH_DOT) ||
                 (match_st == M_CRLFDOT && b == smtp_eod_pkg::CH_CR))
        begin
            match_st = match_t'(match_st + 3'd1);
        end
        else if (match_st == M_CRLFDOTCR && b == smtp_eod_pkg::CH_LF)
        begin
            r = '{8'h00, 1'b0, 1'b1, 1'b0};
            released.push_back(r);
            match_st = M_DONE;
        end
        else
        begin
            // The match has failed: give back what was held, in order.
            for (k = 0; k < int'(match_st); k++)
            begin
                r = '{term_seq[k], 1'b1, 1'b0, 1'b0};
                released.push_back(r);
            end
            // A breaking CR is kept back as the start of a fresh match.
            if (b == smtp_eod_pkg::CH_CR)
            begin
                match_st = M_CR;
            end
            else
            begin
                r = '{b, 1'b1, 1'b0, 1'b0};
                released.push_back(r);
                match_st = M_BODY;
            end
        end
        if (released.size() > 0)
        begin
            r = released.pop_back();
            r.lst = 1'b1;
            released.push_back(r);
        end
    endtask

    // Offers one item and holds it until the block takes it, then idles for a
    // random stretch as the current phase asks. Valid is only ever raised in a
    // fresh time step, so no step sees it lowered and raised at once.
    task automatic send_item(input logic op, input logic [7:0] b);
        operation <= op;
        in_byte   <= b;
        in_valid  <= 1'b1;
        do @(posedge clk); while (in_stall);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // Random-part item: counts it where it does anything and moves through the
    // idling phases as the count grows.
    task automatic offer(input logic op, input logic [7:0] b, input bit counted);
        phase_t p;
        send_item(op, b);
        if (counted)
            n_items++;
        p = phase_t'((n_items * 5) / RAND_ITEMS);
        if (p > PH_BOTH)
            p = PH_BOTH;
        phase = p;
        case (p)
            PH_SEND_IDLE:  begin send_idle_pct = 83; stall_pct = 0;  end
            PH_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 83; end
            PH_BOTH:       begin send_idle_pct = 14; stall_pct = 14; end
            default:       begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Body bytes with a strong bias towards the terminator characters, so that
    // partial matches open and fail often.
    function automatic logic [7:0] body_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'($urandom);
        else if (r < 62)
            return smtp_eod_pkg::CH_CR;
        else if (r < 77)
            return smtp_eod_pkg::CH_LF;
        else if (r < 90)
            return smtp_eod_pkg::CH_DOT;
        else
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endfunction

    // Sender.
    initial
    begin
        int sel;
        int len;
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_N; k++)
            send_item(dir_tab[k].op, dir_tab[k].data);

        // Random part: mostly message text, with whole terminators followed by
        // a restart, partial terminators followed by an arbitrary byte, and a few
        // stray restarts.
        while (n_items < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
            begin
                len = $urandom_range(1, 8);
                repeat (len) offer(OP_FEED, body_byte(), 1'b1);
            end
            else if (sel < 80)
            begin
                for (k = 0; k < 5; k++)
                    offer(OP_FEED, term_seq[k], 1'b1);
                // Bytes after the terminator are ignored and not counted.
                repeat ($urandom_range(0, 2)) offer(OP_FEED, 8'($urandom), 1'b0);
                offer(OP_RESTART, 8'($urandom), 1'b1);
            end
            else if (sel < 93)
            begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    offer(OP_FEED, term_seq[k], 1'b1);
                offer(OP_FEED, body_byte(), 1'b1);
            end
            else
            begin
                offer(OP_RESTART, 8'($urandom), 1'b1);
            end
        end
        in_valid <= 1'b0;

        // Drain, then allow for an item still in flight that gives nothing.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (n_fail == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver. On entering the pressure phase it holds off for a long stretch
    // while the sender keeps offering, so the job queue fills and the block
    // stalls its input; otherwise it stalls at the phase's rate.
    initial
    begin
        phase_t seen;
        int     hold_left;
        seen = PH_FREE;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (phase != seen)
            begin
                seen = phase;
                if (phase == PH_PRESSURE)
                    hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Monitor. All inputs are driven with nonblocking assignments at the edge,
    // so the values read here are those that the block saw at this edge. The
    // prediction for an accepted item is queued before any result is checked.
    always @(posedge clk)
    begin
        eod_res_t got;
        eod_res_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                terminator_step(operation, in_byte);
                if (n_accepted < DIR_N && dir_tab[n_accepted].typed)
                begin
                    if (dir_tab[n_accepted].n_res)
                        pending_results.push_back(dir_tab[n_accepted].res);
                end
                else
                begin
                    foreach (released[i])
                        pending_results.push_back(released[i]);
                end
                n_accepted++;
            end

            if (out_valid && !out_stall)
            begin
                got = '{out_byte, byte_valid, end_of_message, last};
                if (pending_results.size() == 0)
                begin
                    $error("result item with none expected: out_byte %02h", out_byte);
                    n_fail++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.data !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, got.data);
                        n_fail++;
                    end
                    if (got.vld !== want.vld)
                    begin
                        $error("byte_valid: expected %0b, got %0b", want.vld, got.vld);
                        n_fail++;
                    end
                    if (got.eom !== want.eom)
                    begin
                        $error("end_of_message: expected %0b, got %0b", want.eom, got.eom);
                        n_fail++;
                    end
                    if (got.lst !== want.lst)
                    begin
                        $error("last: expected %0b, got %0b", want.lst, got.lst);
                        n_fail++;
                    end
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no item moving on either side means
    // the block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet <= 0;
            end
            else if (quiet + 1 >= QUIET_MAX)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

endmodule

FILE: sim.f
rtl/smtp_eod_pkg.sv
rtl/smtp_eod_front.sv
rtl/smtp_eod_fifo.sv
rtl/smtp_eod_back.sv
rtl/smtp_end_of_data_detector.sv
verif/tb_smtp_end_of_data_detector.sv
